### hdl/sync_frame_checksum_receiver_defines.svh
// Assertion macros used by the sync frame checksum receiver parser.
`ifndef SYNC_FRAME_CHECKSUM_RECEIVER_DEFINES_SVH
`define SYNC_FRAME_CHECKSUM_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFCR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFCR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/sfcr_pkg.sv
// Shared types and constants of the sync frame checksum receiver.
package sfcr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam int         PAYLOAD_LEN = 12;
  localparam int         CNT_W       = $clog2(PAYLOAD_LEN + 1);

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_SYNC2   = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CHECK   = 4'b1000
  } phase_t;

  // One decoded frame result.
  typedef struct packed {
    logic               frame_ok;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic               camera_flag;
    logic               on_flag;
    logic signed [15:0] angle_deg;
    logic [15:0]        dist_now;
    logic [15:0]        dist_limit;
    logic [7:0]         sum_received;
    logic [7:0]         sum_computed;
  } res_t;

  // Parser status toward the pipeline control.
  typedef struct packed {
    logic check_phase;
  } parse_stat_t;

endpackage

### hdl/sfcr_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface sfcr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcr_res_if;
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic               camera_flag;
  logic               on_flag;
  logic signed [15:0] angle_deg;
  logic [15:0]        dist_now;
  logic [15:0]        dist_limit;
  logic [7:0]         sum_received;
  logic [7:0]         sum_computed;

  modport source (
    output valid, output frame_ok, output pos_x, output pos_y, output camera_flag,
    output on_flag, output angle_deg, output dist_now, output dist_limit,
    output sum_received, output sum_computed, input ready
  );
  modport sink (
    input valid, input frame_ok, input pos_x, input pos_y, input camera_flag,
    input on_flag, input angle_deg, input dist_now, input dist_limit,
    input sum_received, input sum_computed, output ready
  );
endinterface

### hdl/sfcr_in_stage.sv
// Input register: captures one received byte per transaction.
module sfcr_in_stage (
  input  logic       clk,
  input  logic       rst,
  sfcr_byte_if.sink  rx,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic accept;
  logic byte_valid_next;

  // Take a new byte when the register is empty or moving on this cycle.
  assign rx.ready = !byte_valid || advance;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    byte_valid_next = byte_valid;
    if (accept) begin
      byte_valid_next = 1'b1;
    end else if (advance) begin
      byte_valid_next = 1'b0;
    end
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= byte_valid_next;
    end
  end

  // Capture payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_data <= rx.rx_byte;
    end
  end

endmodule

### hdl/sfcr_parser.sv
// Frame parser: sync hunt, payload capture, running sum and result decode.
`include "sync_frame_checksum_receiver_defines.svh"

module sfcr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_data,
  output sfcr_pkg::parse_stat_t stat,
  output logic                res_load,
  output sfcr_pkg::res_t      res
);
  import sfcr_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [7:0]        running_sum;
  logic [7:0]        running_sum_next;
  logic [7:0]        payload [PAYLOAD_LEN];
  logic              store_wr;
  logic              sum_ok;

  assign stat.check_phase = (phase == PH_CHECK);

  // Advance the phase on each stepped byte.
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    store_wr         = 1'b0;
    if (step) begin
      case (phase)
        PH_HUNT: begin
          if (byte_data == SYNC_FIRST) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (byte_data == SYNC_SECOND) begin
            phase_next       = PH_PAYLOAD;
            byte_count_next  = '0;
            running_sum_next = '0;
          end else if (byte_data != SYNC_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          store_wr         = 1'b1;
          running_sum_next = running_sum + byte_data;
          byte_count_next  = byte_count + CNT_W'(1);
          if (byte_count_next == CNT_W'(PAYLOAD_LEN)) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // Store payload bytes in arrival order.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      payload[byte_count] <= byte_data;
    end
  end

  // Decode the frame on the checksum byte; zero the fields on a mismatch.
  assign sum_ok   = (byte_data == running_sum);
  assign res_load = step && (phase == PH_CHECK);

  always_comb begin
    res              = '0;
    res.frame_ok     = sum_ok;
    res.sum_received = byte_data;
    res.sum_computed = running_sum;
    if (sum_ok) begin
      res.pos_x       = {payload[1], payload[0]};
      res.pos_y       = {payload[3], payload[2]};
      res.camera_flag = (payload[4] != 8'h00);
      res.on_flag     = (payload[5] != 8'h00);
      res.angle_deg   = $signed({payload[7], payload[6]});
      res.dist_now    = {payload[9], payload[8]};
      res.dist_limit  = {payload[11], payload[10]};
    end
  end

  `SFCR_ASSERT_NEXT(a_check_returns_hunt, clk, rst, step && (phase == PH_CHECK), phase == PH_HUNT, "frame did not return to hunt after checksum")
  `SFCR_ASSERT_IMPLY(a_count_in_range, clk, rst, phase == PH_PAYLOAD, byte_count < CNT_W'(PAYLOAD_LEN), "payload count out of range")
  `SFCR_ASSERT_NEXT(a_sync_clears, clk, rst, step && (phase == PH_SYNC2) && (byte_data == SYNC_SECOND), (byte_count == '0) && (running_sum == '0), "sync pair did not restart the frame")

endmodule

### hdl/sfcr_out_stage.sv
// Result register: holds one frame result until the sink takes it.
module sfcr_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_load,
  input  sfcr_pkg::res_t res_in,
  output logic           slot_free,
  sfcr_res_if.source     res
);

  sfcr_pkg::res_t hold;
  logic           res_valid;
  logic           res_valid_next;

  assign slot_free = !res_valid || res.ready;

  always_comb begin
    res_valid_next = res_valid;
    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (res.ready) begin
      res_valid_next = 1'b0;
    end
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  // Capture the result payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      hold <= res_in;
    end
  end

  // Drive the result channel.
  assign res.valid        = res_valid;
  assign res.frame_ok     = hold.frame_ok;
  assign res.pos_x        = hold.pos_x;
  assign res.pos_y        = hold.pos_y;
  assign res.camera_flag  = hold.camera_flag;
  assign res.on_flag      = hold.on_flag;
  assign res.angle_deg    = hold.angle_deg;
  assign res.dist_now     = hold.dist_now;
  assign res.dist_limit   = hold.dist_limit;
  assign res.sum_received = hold.sum_received;
  assign res.sum_computed = hold.sum_computed;

endmodule

### hdl/sync_frame_checksum_receiver.sv
// Sync frame checksum receiver: byte stream in, one decoded frame result out.
//
// Accepts one serial byte per cycle on rx and hunts for the sync pair 0xAA 0x55,
// then collects a 12-byte payload while summing it modulo 256. The byte after
// the payload is the checksum; it yields exactly one transaction on res with
// frame_ok set when it equals the sum (payload fields zero otherwise), and the
// parser goes back to the hunt. All other bytes yield nothing. Throughput is
// one byte per cycle while nothing stalls: a byte is held in the input register
// while the parser updates its state, and a checksum byte loads the result
// register at the edge where the parser steps it, so res.valid rises from the
// result register once the checksum byte has passed the input register. Only
// a result still waiting on res stalls a checksum byte in the input register,
// and the input stalls with it until the result is taken; no other byte ever
// waits.
module sync_frame_checksum_receiver (
  input  logic       clk,
  input  logic       rst,
  sfcr_byte_if.sink  rx,
  sfcr_res_if.source res
);
  import sfcr_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        advance;
  logic        step;
  logic        slot_free;
  logic        res_load;
  parse_stat_t stat;
  res_t        res_next;

  // Move the held byte on unless it needs a result slot that is still full.
  assign advance = !stat.check_phase || slot_free;
  assign step    = byte_valid && advance;

  sfcr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  sfcr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_data (byte_data),
    .stat      (stat),
    .res_load  (res_load),
    .res       (res_next)
  );

  sfcr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res_in    (res_next),
    .slot_free (slot_free),
    .res       (res)
  );

endmodule
